// ===== design/matrix_keypad_scanner_macros.svh =====
// Assertion macros used by the keypad scanner checker.
`ifndef MATRIX_KEYPAD_SCANNER_MACROS_SVH
`define MATRIX_KEYPAD_SCANNER_MACROS_SVH

// Checks a property on the rising clock edge while out of reset.
`define KPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on the rising clock edge, including reset cycles.
`define KPS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/kps_pkg.sv =====
// Package with the types, constants and helper functions of the keypad scanner.
package kps_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PRESS    = 3'd1,
    PH_DEBOUNCE = 3'd2,
    PH_SCAN     = 3'd3,
    PH_RELEASE  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [3:0] row_drive;
    logic       key_valid;
    logic [1:0] key_row;
    logic [1:0] key_col;
    logic       echo_enable;
  } res_t;

  localparam logic [3:0]  COLS_IDLE      = 4'hF;
  localparam logic [3:0]  ALL_ROWS       = 4'h0;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [1:0]  LOCK_ROW       = 2'd3;
  localparam logic [1:0]  COL_UNLOCK     = 2'd0;
  localparam logic [1:0]  COL_LOCK       = 2'd2;

  function automatic logic [3:0] row_pattern(input logic [1:0] row);
    row_pattern = ~(4'b0001 << row);
  endfunction

  function automatic logic [1:0] col_index(input logic [3:0] cols);
    case (cols)
      4'b1110: col_index = 2'd0;
      4'b1101: col_index = 2'd1;
      4'b1011: col_index = 2'd2;
      default: col_index = 2'd3;
    endcase
  endfunction

endpackage

// ===== design/kps_in_reg.sv =====
// Input register that holds one column sample until the scan logic takes it.
module kps_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_col_sense,
  input  logic       advance,
  output logic       held_valid,
  output logic [3:0] held_col
);

  logic       valid_r, valid_nxt;
  logic [3:0] col_r, col_nxt;

  assign in_stall = valid_r && !advance;

  always_comb begin
    valid_nxt = valid_r;
    col_nxt   = col_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
      if (in_valid) begin
        col_nxt = in_col_sense;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    col_r <= col_nxt;
  end

  assign held_valid = valid_r;
  assign held_col   = col_r;

endmodule

// ===== design/kps_core.sv =====
// Scan state machine that turns one column sample into one result.
module kps_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [3:0]    col_sense,
  input  logic [15:0]   debounce_ticks,
  output kps_pkg::res_t result
);

  kps_pkg::phase_t phase_r, phase_nxt;
  logic            confirm_r, confirm_nxt;
  logic [15:0]     count_r, count_nxt;
  logic [1:0]      row_r, row_nxt;
  logic [3:0]      cols_r, cols_nxt;
  logic            lock_r, lock_nxt;
  logic            idle_s;
  logic            done_wait;
  logic [1:0]      kcol;

  assign idle_s    = (col_sense == kps_pkg::COLS_IDLE);
  assign done_wait = (count_r >= debounce_ticks);
  assign kcol      = kps_pkg::col_index(cols_r);

  always_comb begin
    phase_nxt   = phase_r;
    confirm_nxt = confirm_r;
    count_nxt   = count_r;
    row_nxt     = row_r;
    cols_nxt    = cols_r;
    lock_nxt    = lock_r;
    case (phase_r)
      kps_pkg::PH_PRESS: begin
        if (!idle_s) begin
          if (confirm_r) begin
            confirm_nxt = 1'b0;
            count_nxt   = '0;
            phase_nxt   = kps_pkg::PH_DEBOUNCE;
          end else begin
            confirm_nxt = 1'b1;
          end
        end else begin
          confirm_nxt = 1'b0;
        end
      end
      kps_pkg::PH_DEBOUNCE: begin
        if (done_wait) begin
          row_nxt   = '0;
          phase_nxt = kps_pkg::PH_SCAN;
        end else begin
          count_nxt = count_r + 16'd1;
        end
      end
      kps_pkg::PH_SCAN: begin
        if (!idle_s) begin
          cols_nxt  = col_sense;
          phase_nxt = kps_pkg::PH_RELEASE;
        end else begin
          row_nxt = row_r + 2'd1;
        end
      end
      kps_pkg::PH_RELEASE: begin
        if (idle_s) begin
          if (row_r == kps_pkg::LOCK_ROW && kcol == kps_pkg::COL_UNLOCK) begin
            lock_nxt = 1'b0;
          end else if (row_r == kps_pkg::LOCK_ROW && kcol == kps_pkg::COL_LOCK) begin
            lock_nxt = 1'b1;
          end
          confirm_nxt = 1'b0;
          phase_nxt   = kps_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = kps_pkg::PH_IDLE;
        if (idle_s) begin
          if (confirm_r) begin
            confirm_nxt = 1'b0;
            phase_nxt   = kps_pkg::PH_PRESS;
          end else begin
            confirm_nxt = 1'b1;
          end
        end else begin
          confirm_nxt = 1'b0;
        end
      end
    endcase
  end

  always_comb begin
    result           = '0;
    result.row_drive = kps_pkg::ALL_ROWS;
    case (phase_r)
      kps_pkg::PH_DEBOUNCE: begin
        if (done_wait) begin
          result.row_drive = kps_pkg::row_pattern(2'd0);
        end
      end
      kps_pkg::PH_SCAN: begin
        result.row_drive = kps_pkg::row_pattern(row_nxt);
      end
      kps_pkg::PH_RELEASE: begin
        if (idle_s) begin
          result.key_valid = 1'b1;
          result.key_row   = row_r;
          result.key_col   = kcol;
          if (kcol == kps_pkg::COL_LOCK && row_r == kps_pkg::LOCK_ROW) begin
            result.echo_enable = 1'b0;
          end else begin
            result.echo_enable = !lock_r;
          end
        end else begin
          result.row_drive = kps_pkg::row_pattern(row_r);
        end
      end
      default: begin
        result.row_drive = kps_pkg::ALL_ROWS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= kps_pkg::PH_IDLE;
      confirm_r <= 1'b0;
      count_r   <= '0;
      row_r     <= '0;
      cols_r    <= kps_pkg::COLS_IDLE;
      lock_r    <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      confirm_r <= confirm_nxt;
      count_r   <= count_nxt;
      row_r     <= row_nxt;
      cols_r    <= cols_nxt;
      lock_r    <= lock_nxt;
    end
  end

endmodule

// ===== design/kps_out_reg.sv =====
// Result register that holds one result until the receiving side takes it.
module kps_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          held_valid,
  input  kps_pkg::res_t result,
  input  logic          out_stall,
  output logic          advance,
  output logic          out_valid,
  output kps_pkg::res_t out_res
);

  logic          valid_r, valid_nxt;
  kps_pkg::res_t res_r, res_nxt;
  logic          take;

  assign take    = !valid_r || !out_stall;
  assign advance = held_valid && take;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (take) begin
      valid_nxt = held_valid;
    end
    if (advance) begin
      res_nxt = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== design/matrix_keypad_scanner.sv =====
// The scanner takes one column sample per transaction and gives one result for each, in
// order. A sample is held in an input register, and the state machine decides the row drive
// and the key report on the way into the result register. A result is therefore offered
// by the result register once its sample has passed the input register. With no stall, both
// registers pass a transaction on in every cycle, so a new sample can be accepted in every
// clock cycle. A stalled result holds the result register; the input register then fills and
// stalls the input. The debounce register is written through its own port, which is always
// ready, and takes effect on the next sample.
module matrix_keypad_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_col_sense,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_row_drive,
  output logic        out_key_valid,
  output logic [1:0]  out_key_row,
  output logic [1:0]  out_key_col,
  output logic        out_echo_enable,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_debounce_ticks
);

  logic [15:0]   debounce_ticks_r, debounce_ticks_nxt;
  logic          held_valid;
  logic [3:0]    held_col;
  logic          advance;
  kps_pkg::res_t result;
  kps_pkg::res_t out_res;

  assign cfg_ready = 1'b1;

  always_comb begin
    debounce_ticks_nxt = debounce_ticks_r;
    if (cfg_valid && cfg_ready) begin
      debounce_ticks_nxt = cfg_debounce_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= kps_pkg::DEBOUNCE_RESET;
    end else begin
      debounce_ticks_r <= debounce_ticks_nxt;
    end
  end

  kps_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_col_sense (in_col_sense),
    .advance      (advance),
    .held_valid   (held_valid),
    .held_col     (held_col)
  );

  kps_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .col_sense      (held_col),
    .debounce_ticks (debounce_ticks_r),
    .result         (result)
  );

  kps_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .held_valid (held_valid),
    .result     (result),
    .out_stall  (out_stall),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_res    (out_res)
  );

  assign out_row_drive   = out_res.row_drive;
  assign out_key_valid   = out_res.key_valid;
  assign out_key_row     = out_res.key_row;
  assign out_key_col     = out_res.key_col;
  assign out_echo_enable = out_res.echo_enable;

endmodule

// ===== design/kps_checker.sv =====
// Checker on the ports of the keypad scanner, bound to its top level.
`include "matrix_keypad_scanner_macros.svh"

module kps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_row_drive,
  input logic       out_key_valid,
  input logic [1:0] out_key_row,
  input logic [1:0] out_key_col,
  input logic       out_echo_enable
);

  `KPS_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "Pipeline not empty after reset")

  `KPS_ASSERT(a_report_all_rows, out_valid && out_key_valid |-> out_row_drive == 4'b0000, "Key report without all rows driven")

  `KPS_ASSERT(a_lock_key_silent, out_valid && out_key_valid && out_key_row == 2'd3 && out_key_col == 2'd2 |-> !out_echo_enable, "Lock key was echoed")

  `KPS_ASSERT(a_drive_shape, out_valid |-> $countones(out_row_drive) == 0 || $countones(out_row_drive) == 3, "Row drive has more than one row or a partial pattern")

  `KPS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_row_drive) && $stable(out_key_valid), "Stalled result changed")

endmodule

bind matrix_keypad_scanner kps_checker u_kps_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the keypad scanner: planned key sequences, noise and idling.
module testbench;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int ROUNDS = 10;
  localparam int ROUND_ITEMS = 95;

  typedef struct packed {
    kps_pkg::phase_t phase;
    logic            confirm;
    logic [15:0]     count;
    logic [1:0]      row;
    logic [3:0]      cols;
    logic            lock;
    logic [15:0]     debounce;
  } scan_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_col_sense = kps_pkg::COLS_IDLE;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_row_drive;
  logic        out_key_valid;
  logic [1:0]  out_key_row;
  logic [1:0]  out_key_col;
  logic        out_echo_enable;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_debounce_ticks = 16'd0;

  scan_state_t   keypad_model;
  scan_state_t   keypad_plan;
  logic [3:0]    col_samples[$];
  kps_pkg::res_t expected_reports[$];
  int            in_flight = 0;
  int            live_items = 0;
  int            errors = 0;
  int            results_seen = 0;
  int            cycles = 0;
  int            hold_requests = 0;
  int            hold_served = 0;
  int            hold_left = 0;
  bit            steady = 1'b0;
  bit            in_accepted = 1'b0;

  matrix_keypad_scanner dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_col_sense       (in_col_sense),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_row_drive      (out_row_drive),
    .out_key_valid      (out_key_valid),
    .out_key_row        (out_key_row),
    .out_key_col        (out_key_col),
    .out_echo_enable    (out_echo_enable),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_debounce_ticks (cfg_debounce_ticks)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic scan_tick(inout scan_state_t st, input logic [3:0] cols,
                           output kps_pkg::res_t r);
    logic [1:0] col;
    r = '0;
    r.row_drive = kps_pkg::ALL_ROWS;
    case (st.phase)
      kps_pkg::PH_PRESS: begin
        if (cols != kps_pkg::COLS_IDLE) begin
          if (st.confirm) begin
            st.confirm = 1'b0;
            st.count = 16'd0;
            st.phase = kps_pkg::PH_DEBOUNCE;
          end else begin
            st.confirm = 1'b1;
          end
        end else begin
          st.confirm = 1'b0;
        end
      end
      kps_pkg::PH_DEBOUNCE: begin
        if (st.count >= st.debounce) begin
          st.row = 2'd0;
          st.phase = kps_pkg::PH_SCAN;
          r.row_drive = 4'b1110;
        end else begin
          st.count = st.count + 16'd1;
        end
      end
      kps_pkg::PH_SCAN: begin
        if (cols != kps_pkg::COLS_IDLE) begin
          st.cols = cols;
          st.phase = kps_pkg::PH_RELEASE;
        end else begin
          st.row = st.row + 2'd1;
        end
        r.row_drive = ~(4'b0001 << st.row);
      end
      kps_pkg::PH_RELEASE: begin
        if (cols == kps_pkg::COLS_IDLE) begin
          case (st.cols)
            4'b1110: col = 2'd0;
            4'b1101: col = 2'd1;
            4'b1011: col = 2'd2;
            default: col = 2'd3;
          endcase
          r.key_valid = 1'b1;
          r.key_row = st.row;
          r.key_col = col;
          if (col == kps_pkg::COL_LOCK && st.row == kps_pkg::LOCK_ROW) st.lock = 1'b1;
          r.echo_enable = !st.lock;
          if (col == kps_pkg::COL_UNLOCK && st.row == kps_pkg::LOCK_ROW) st.lock = 1'b0;
          st.confirm = 1'b0;
          st.phase = kps_pkg::PH_IDLE;
        end else begin
          r.row_drive = ~(4'b0001 << st.row);
        end
      end
      default: begin
        st.phase = kps_pkg::PH_IDLE;
        if (cols == kps_pkg::COLS_IDLE) begin
          if (st.confirm) begin
            st.confirm = 1'b0;
            st.phase = kps_pkg::PH_PRESS;
          end else begin
            st.confirm = 1'b1;
          end
        end else begin
          st.confirm = 1'b0;
        end
      end
    endcase
  endtask

  task report_mismatch(input string what, input int got, input int want);
    $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  task automatic queue_sample(input logic [3:0] cols, output kps_pkg::res_t r);
    live_items++;
    scan_tick(keypad_plan, cols, r);
    col_samples.push_back(cols);
  endtask

  // Feeds samples that a real press of the given key would give, from whatever state the
  // scanner is planned to be in, until the key is reported on its release.
  task automatic queue_key(input logic [1:0] row, input logic [3:0] cols, input int hold);
    kps_pkg::res_t r;
    logic [3:0]    s;
    int            held;
    held = 0;
    r = '0;
    while (!r.key_valid) begin
      case (keypad_plan.phase)
        kps_pkg::PH_PRESS: s = cols;
        kps_pkg::PH_DEBOUNCE: s = 4'($urandom_range(0, 15));
        kps_pkg::PH_SCAN: s = (keypad_plan.row == row) ? cols : kps_pkg::COLS_IDLE;
        kps_pkg::PH_RELEASE: begin
          if (held < hold) begin
            s = 4'($urandom_range(0, 14));
            held++;
          end else begin
            s = kps_pkg::COLS_IDLE;
          end
        end
        default: s = kps_pkg::COLS_IDLE;
      endcase
      queue_sample(s, r);
    end
  endtask

  task automatic queue_noise(input int n);
    kps_pkg::res_t r;
    for (int i = 0; i < n; i++) begin
      queue_sample($urandom_range(0, 1) ? kps_pkg::COLS_IDLE : 4'($urandom_range(0, 15)), r);
    end
  endtask

  function automatic logic [3:0] pick_cols();
    case ($urandom_range(0, 5))
      0: return 4'b1110;
      1: return 4'b1101;
      2: return 4'b1011;
      3: return 4'b0111;
      default: return 4'($urandom_range(0, 14));
    endcase
  endfunction

  task automatic write_debounce(input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_debounce_ticks <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    keypad_model.debounce = value;
    keypad_plan.debounce = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (col_samples.size() > 0 || in_flight > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(negedge clk) begin : driver
    if (rst_n && (!in_valid || in_accepted)) begin
      if (col_samples.size() > 0 && (steady || $urandom_range(0, 99) >= 27)) begin
        in_col_sense <= col_samples.pop_front();
        in_valid <= 1'b1;
        in_flight++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 27);
    end
  end

  always @(posedge clk) begin : monitor
    kps_pkg::res_t predicted;
    kps_pkg::res_t want;
    in_accepted <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      scan_tick(keypad_model, in_col_sense, predicted);
      expected_reports.push_back(predicted);
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = expected_reports.pop_front();
        in_flight--;
        if (out_row_drive != want.row_drive)
          report_mismatch("row_drive", out_row_drive, want.row_drive);
        if (out_key_valid != want.key_valid)
          report_mismatch("key_valid", out_key_valid, want.key_valid);
        if (out_key_row != want.key_row)
          report_mismatch("key_row", out_key_row, want.key_row);
        if (out_key_col != want.key_col)
          report_mismatch("key_col", out_key_col, want.key_col);
        if (out_echo_enable != want.echo_enable)
          report_mismatch("echo_enable", out_echo_enable, want.echo_enable);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    kps_pkg::res_t scratch;
    int            choice;
    int            target;
    logic [15:0]   ticks;
    keypad_model = '{kps_pkg::PH_IDLE, 1'b0, 16'd0, 2'd0, kps_pkg::COLS_IDLE, 1'b0,
                     kps_pkg::DEBOUNCE_RESET};
    keypad_plan = keypad_model;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // The reset debounce count is used first, with the lock set, kept and cleared.
    queue_key(kps_pkg::LOCK_ROW, 4'b1011, 0);
    queue_key(2'd1, 4'b1110, 1);
    queue_key(kps_pkg::LOCK_ROW, 4'b1110, 0);
    queue_key(2'd2, 4'b1101, 2);
    queue_key(2'd0, 4'b0000, 1);
    queue_key(kps_pkg::LOCK_ROW, 4'b0111, 0);
    while (!(keypad_plan.phase == kps_pkg::PH_DEBOUNCE && keypad_plan.count == 16'd5)) begin
      queue_sample((keypad_plan.phase == kps_pkg::PH_IDLE) ? kps_pkg::COLS_IDLE : 4'b1011,
                   scratch);
    end
    wait_drained();

    // Lowering the count below the progress already made ends the wait on the next sample.
    write_debounce(16'd2);
    queue_key(2'd1, 4'b1101, 0);
    wait_drained();

    write_debounce(16'd0);
    queue_key(kps_pkg::LOCK_ROW, 4'b1011, 1);
    queue_key(2'd2, 4'b1011, 0);
    wait_drained();

    steady = 1'b1;
    write_debounce(16'd200);
    queue_key(2'd0, 4'b1110, 1);
    wait_drained();
    steady = 1'b0;

    for (int round = 0; round < ROUNDS; round++) begin
      ticks = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 40))
                                          : 16'($urandom_range(0, 6));
      write_debounce(ticks);
      target = live_items + ROUND_ITEMS;
      while (live_items < target) begin
        choice = $urandom_range(0, 99);
        if (choice < 72) begin
          queue_key(2'($urandom_range(0, 3)), pick_cols(), $urandom_range(0, 4));
        end else begin
          queue_noise($urandom_range(1, 8));
        end
      end
      if (round == 3) hold_requests++;
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (expected_reports.size() != 0)
      report_mismatch("transactions never delivered", expected_reports.size(), 0);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/kps_pkg.sv
design/kps_in_reg.sv
design/kps_core.sv
design/kps_out_reg.sv
design/matrix_keypad_scanner.sv
design/kps_checker.sv
bench/testbench.sv
